// ----- design/sma_pkg.sv -----
// Shared types and constants for the sign-magnitude arithmetic unit.
`default_nettype none

package sma_pkg;

  localparam int IN_FIELD_W = 16;
  localparam int RESULT_W   = 32;
  localparam int DEF_WIDTH  = 16;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [IN_FIELD_W-1:0] x_operand;
    logic [IN_FIELD_W-1:0] y_operand;
  } in_word_t;

  typedef struct packed {
    logic [RESULT_W-1:0] result_value;
    logic                overflow;
  } out_word_t;

  // Per-item side data that rides along the multiplier stages.
  typedef struct packed {
    func_e               op;
    logic                neg;
    logic                ovf;
    logic [RESULT_W-1:0] sum;
  } side_t;

endpackage

`default_nettype wire

// ----- design/sma_front.sv -----
// First stage: operand decode, two's complement sum and multiplier operand setup.
`default_nettype none

module sma_front import sma_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH,
  localparam int MW   = (WIDTH > IN_FIELD_W) ? IN_FIELD_W : WIDTH - 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire in_word_t      word_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [MW-1:0]      mcand_o,
  output logic [MW-1:0]      mplier_o
);

  localparam logic [WIDTH-1:0] TOP = {1'b1, {(WIDTH-1){1'b0}}};

  logic [WIDTH-2:0] xm, ym;
  logic             xs, ys_raw, ys;
  logic [WIDTH-1:0] xinv, yinv, sum;
  logic             sa, sb, ss;
  func_e            op;
  side_t            side_d, side_q;
  logic             valid_q;
  logic [MW-1:0]    mcand_q, mplier_q;

  // Operands wider than the input field are non-negative.
  if (WIDTH > IN_FIELD_W) begin : g_wide
    assign xm     = (WIDTH-1)'(word_i.x_operand);
    assign ym     = (WIDTH-1)'(word_i.y_operand);
    assign xs     = 1'b0;
    assign ys_raw = 1'b0;
  end else begin : g_narrow
    assign xm     = word_i.x_operand[WIDTH-2:0];
    assign ym     = word_i.y_operand[WIDTH-2:0];
    assign xs     = word_i.x_operand[WIDTH-1];
    assign ys_raw = word_i.y_operand[WIDTH-1];
  end

  always_comb begin
    op   = func_e'(word_i.func);
    ys   = ys_raw ^ (op == FUNC_SUB);
    // Fold both negations into the carry-in of a single add.
    xinv = xs ? ~{1'b0, xm} : {1'b0, xm};
    yinv = ys ? ~{1'b0, ym} : {1'b0, ym};
    sum  = xinv + yinv + WIDTH'(xs) + WIDTH'(ys);
    sa   = xs & (|xm);
    sb   = ys & (|ym);
    ss   = sum[WIDTH-1];
    side_d.op  = op;
    side_d.neg = xs ^ ys_raw;
    side_d.ovf = ((sa == sb) && (ss != sa)) || (sum == TOP);
    side_d.sum = RESULT_W'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q   <= side_d;
      mcand_q  <= xm[MW-1:0];
      mplier_q <= ym[MW-1:0];
    end
  end

  assign valid_o  = valid_q;
  assign side_o   = side_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;

endmodule

`default_nettype wire

// ----- design/sma_booth_stage.sv -----
// One pipeline stage of radix-2 Booth recoding over a fixed slice of multiplier bits.
`default_nettype none

module sma_booth_stage import sma_pkg::*; #(
  parameter int MW    = 15,
  parameter int BASE  = 0,
  parameter int CNT   = 6,
  localparam int ACC_W = 2 * MW + 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire side_t            side_i,
  input  wire logic [MW-1:0]    mcand_i,
  input  wire logic [MW-1:0]    mplier_i,
  input  wire logic [ACC_W-1:0] acc_i,
  output logic                  valid_o,
  output side_t                 side_o,
  output logic [MW-1:0]         mcand_o,
  output logic [MW-1:0]         mplier_o,
  output logic [ACC_W-1:0]      acc_o
);

  localparam logic [1:0] BOOTH_ADD = 2'b01;
  localparam logic [1:0] BOOTH_SUB = 2'b10;

  logic [MW+1:0]    yext;
  logic [ACC_W-1:0] acc_d, acc_q;
  logic             valid_q;
  side_t            side_q;
  logic [MW-1:0]    mcand_q, mplier_q;

  always_comb begin
    yext  = {1'b0, mplier_i, 1'b0};
    acc_d = acc_i;
    for (int j = 0; j < CNT; j++) begin
      case (yext[BASE+j+1 -: 2])
        BOOTH_ADD: acc_d = acc_d + (ACC_W'(mcand_i) << (BASE + j));
        BOOTH_SUB: acc_d = acc_d - (ACC_W'(mcand_i) << (BASE + j));
        default:   acc_d = acc_d;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q   <= side_i;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= acc_d;
    end
  end

  assign valid_o  = valid_q;
  assign side_o   = side_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;
  assign acc_o    = acc_q;

endmodule

`default_nettype wire

// ----- design/sma_pack.sv -----
// Last stage: convert the sum or product back to sign-magnitude into the output register.
`default_nettype none

module sma_pack import sma_pkg::*; #(
  parameter int WIDTH  = DEF_WIDTH,
  localparam int MW    = (WIDTH > IN_FIELD_W) ? IN_FIELD_W : WIDTH - 1,
  localparam int ACC_W = 2 * MW + 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire side_t            side_i,
  input  wire logic [ACC_W-1:0] acc_i,
  output logic                  valid_o,
  output out_word_t             word_o
);

  logic [RESULT_W-1:0] sign_mask;
  logic [WIDTH-1:0]    s, neg_s;
  logic [RESULT_W-1:0] prod;
  out_word_t           word_d, word_q;
  logic                valid_q;

  // The product sign bit only lands inside the result field for narrow operands.
  if (2 * WIDTH <= RESULT_W) begin : g_sign
    assign sign_mask = RESULT_W'(1) << (2 * WIDTH - 1);
  end else begin : g_nosign
    assign sign_mask = '0;
  end

  always_comb begin
    s      = side_i.sum[WIDTH-1:0];
    neg_s  = -s;
    prod   = RESULT_W'(acc_i);
    word_d = '0;
    case (side_i.op)
      FUNC_ADD, FUNC_SUB: begin
        if (side_i.ovf) begin
          word_d.overflow = 1'b1;
        end else if (s[WIDTH-1]) begin
          word_d.result_value = RESULT_W'({1'b1, neg_s[WIDTH-2:0]});
        end else begin
          word_d.result_value = RESULT_W'(s);
        end
      end
      FUNC_MUL: begin
        if (side_i.neg && (prod != '0)) begin
          word_d.result_value = prod | sign_mask;
        end else begin
          word_d.result_value = prod;
        end
      end
      default: word_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

`default_nettype wire

// ----- design/sign_magnitude_alu_booth_multiply_unit.sv -----
// Top level of the sign-magnitude add, subtract and Booth multiply unit.
// Takes one word per cycle while in_stall_o is low and returns one result word per word,
// in order. It has one decode and add stage, Booth stages that each retire up to six recoded
// multiplier bits of MW, the magnitude width (WIDTH-1, at most 16), and the output register.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up
// and out_stall_i backs up only as far as needed.
`default_nettype none

module sign_magnitude_alu_booth_multiply_unit import sma_pkg::*; #(
  parameter int WIDTH = DEF_WIDTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  localparam int MW       = (WIDTH > IN_FIELD_W) ? IN_FIELD_W : WIDTH - 1;
  localparam int ACC_W    = 2 * MW + 2;
  localparam int STEPS    = MW + 1;
  localparam int PER_STG  = 6;
  localparam int NB       = (STEPS + PER_STG - 1) / PER_STG;
  localparam int NS       = NB + 2;

  logic [NS-1:0]    v;
  logic [NS-1:0]    en;
  side_t            side [NB+1];
  logic [MW-1:0]    mc   [NB+1];
  logic [MW-1:0]    mp   [NB+1];
  logic [ACC_W-1:0] acc  [NB+1];

  // Advance a stage when it is empty or its successor advances.
  always_comb begin
    en[NS-1] = !v[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  sma_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en[0]),
    .valid_i  (in_valid_i),
    .word_i   (in_word_i),
    .valid_o  (v[0]),
    .side_o   (side[0]),
    .mcand_o  (mc[0]),
    .mplier_o (mp[0])
  );

  assign acc[0] = '0;

  for (genvar k = 0; k < NB; k++) begin : g_booth
    localparam int BASE = k * PER_STG;
    localparam int CNT  = (STEPS - BASE < PER_STG) ? STEPS - BASE : PER_STG;

    sma_booth_stage #(
      .MW   (MW),
      .BASE (BASE),
      .CNT  (CNT)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en[k+1]),
      .valid_i  (v[k]),
      .side_i   (side[k]),
      .mcand_i  (mc[k]),
      .mplier_i (mp[k]),
      .acc_i    (acc[k]),
      .valid_o  (v[k+1]),
      .side_o   (side[k+1]),
      .mcand_o  (mc[k+1]),
      .mplier_o (mp[k+1]),
      .acc_o    (acc[k+1])
    );
  end

  sma_pack #(
    .WIDTH (WIDTH)
  ) u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[NS-1]),
    .valid_i (v[NS-2]),
    .side_i  (side[NB]),
    .acc_i   (acc[NB]),
    .valid_o (v[NS-1]),
    .word_o  (out_word_o)
  );

  assign out_valid_o = v[NS-1];

endmodule

`default_nettype wire
